// File: hdl/rop_pkg.sv
// ----------------------------------------------------------------------------
// rop_pkg
// Shared constants, types and helpers for the rectangle overlap push-out core.
// ----------------------------------------------------------------------------
package rop_pkg;

  // Table depth and pass limit
  localparam int MAX_RECTS = 64;
  localparam int PASSES    = 10;

  // Field widths
  localparam int COORD_W = 24;
  localparam int SIZE_W  = 16;
  localparam int OP_W    = 2;

  // Working position: 24-bit coordinate plus a 16-bit push, with headroom
  localparam int POS_W = COORD_W + 4;

  // Counter and index widths
  localparam int IDX_W   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int COUNT_W = $clog2(MAX_RECTS + 1);
  localparam int PASS_W  = (PASSES > 1) ? $clog2(PASSES) : 1;

  // Stream word widths
  localparam int IN_W  = 2 * COORD_W + 2 * SIZE_W;
  localparam int OUT_W = 2 * COORD_W;

  // Operation codes carried on tuser
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESOLVE = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [SIZE_W-1:0]  dim_t;
  typedef logic signed [POS_W-1:0]   pos_t;
  typedef logic        [POS_W-1:0]   mag_t;

  // Saturation limits expressed at working width
  localparam pos_t POS_HI = pos_t'((2 ** (COORD_W - 1)) - 1);
  localparam pos_t POS_LO = pos_t'(-(2 ** (COORD_W - 1)));

  // One stored rectangle
  typedef struct packed {
    coord_t ox;
    coord_t oy;
    dim_t   ew;
    dim_t   eh;
  } rect_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             load_wr;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
    logic             capture;
    logic             calc_en;
    logic             move_en;
    logic             out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;
    logic out_busy;
  } sts_t;

  // Clamp the working position to the coordinate range
  function automatic coord_t sat_coord(input pos_t v);
    coord_t r;
    if (v > POS_HI) begin
      r = POS_HI[COORD_W-1:0];
    end else if (v < POS_LO) begin
      r = POS_LO[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/rop_ctrl.sv
// ----------------------------------------------------------------------------
// rop_ctrl
// Sequencer: table count, entry walk, pass count and result hand-off.
// ----------------------------------------------------------------------------
module rop_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [rop_pkg::OP_W-1:0] op,
  output rop_pkg::cmd_t            cmd,
  input  rop_pkg::sts_t            sts
);
  import rop_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_MOVE = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]         state, state_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [IDX_W-1:0]   k, k_next;
  logic [PASS_W-1:0]  pass, pass_next;
  logic               any, any_next;

  logic accept;
  logic last_entry;
  logic last_pass;
  logic any_now;

  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign last_entry = ((COUNT_W'(k) + COUNT_W'(1)) == count);
  assign last_pass  = (pass == PASS_W'(PASSES - 1));
  assign any_now    = any || sts.hit;

  // Next-state and command decode
  always_comb begin
    state_next  = state;
    count_next  = count;
    k_next      = k;
    pass_next   = pass;
    any_next    = any;
    cmd         = '0;
    cmd.wr_idx  = count[IDX_W-1:0];
    cmd.rd_idx  = k;

    unique case (state)
      ST_IDLE: begin
        cmd.rd_idx = '0;
        if (accept) begin
          unique case (op)
            OP_CLEAR: begin
              count_next = '0;
            end
            OP_LOAD: begin
              if (count < COUNT_W'(MAX_RECTS)) begin
                cmd.load_wr = 1'b1;
                count_next  = count + COUNT_W'(1);
              end
            end
            OP_RESOLVE: begin
              cmd.capture = 1'b1;
              k_next      = '0;
              pass_next   = '0;
              any_next    = 1'b0;
              state_next  = (count == '0) ? ST_OUT : ST_CALC;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CALC: begin
        cmd.calc_en = 1'b1;
        state_next  = ST_MOVE;
      end
      ST_MOVE: begin
        cmd.move_en = 1'b1;
        any_next    = any_now;
        if (last_entry) begin
          if (!any_now || last_pass) begin
            state_next = ST_OUT;
          end else begin
            // Start the next pass from the first entry
            pass_next  = pass + PASS_W'(1);
            k_next     = '0;
            any_next   = 1'b0;
            cmd.rd_idx = '0;
            state_next = ST_CALC;
          end
        end else begin
          k_next     = k + IDX_W'(1);
          cmd.rd_idx = k + IDX_W'(1);
          state_next = ST_CALC;
        end
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      k     <= '0;
      pass  <= '0;
      any   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      k     <= k_next;
      pass  <= pass_next;
      any   <= any_next;
    end
  end

endmodule

// File: hdl/rop_datapath.sv
// ----------------------------------------------------------------------------
// rop_datapath
// Rectangle table, working position, overlap test, push and output register.
// ----------------------------------------------------------------------------
module rop_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rop_pkg::IN_W-1:0]  s_tdata,
  input  rop_pkg::cmd_t             cmd,
  output rop_pkg::sts_t             sts,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [rop_pkg::OUT_W-1:0] m_tdata
);
  import rop_pkg::*;

  rect_t mem [MAX_RECTS];
  rect_t in_rect;
  rect_t rd_q;

  pos_t pos_x, pos_y;
  dim_t drop_w, drop_h;

  // Edge and distance terms
  pos_t ox_e, oy_e, ex_e, ey_e, rx_e, by_e;
  pos_t dl, dr, du, dd;
  pos_t ndl, ndr, ndu, ndd;
  logic hit_c;

  logic hit_q;
  pos_t dl_q, dr_q, du_q, dd_q;
  mag_t ml_q, mr_q, mu_q, md_q;

  // Unpack the input word
  assign in_rect.ox = s_tdata[COORD_W-1:0];
  assign in_rect.oy = s_tdata[2*COORD_W-1:COORD_W];
  assign in_rect.ew = s_tdata[2*COORD_W+SIZE_W-1:2*COORD_W];
  assign in_rect.eh = s_tdata[2*COORD_W+2*SIZE_W-1:2*COORD_W+SIZE_W];

  // Table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      mem[cmd.wr_idx] <= in_rect;
    end
    rd_q <= mem[cmd.rd_idx];
  end

  // Overlap test and signed edge distances
  always_comb begin
    ox_e  = pos_t'(rd_q.ox);
    oy_e  = pos_t'(rd_q.oy);
    ex_e  = ox_e + pos_t'(rd_q.ew);
    ey_e  = oy_e + pos_t'(rd_q.eh);
    rx_e  = pos_x + pos_t'(drop_w);
    by_e  = pos_y + pos_t'(drop_h);
    hit_c = (pos_x < ex_e) && (rx_e > ox_e) && (pos_y < ey_e) && (by_e > oy_e);
    dl    = ox_e - rx_e;
    ndl   = rx_e - ox_e;
    dr    = ex_e - pos_x;
    ndr   = pos_x - ex_e;
    du    = oy_e - by_e;
    ndu   = by_e - oy_e;
    dd    = ey_e - pos_y;
    ndd   = pos_y - ey_e;
  end

  // Register distances and magnitudes
  always_ff @(posedge clk) begin
    if (cmd.calc_en) begin
      hit_q <= hit_c;
      dl_q  <= dl;
      dr_q  <= dr;
      du_q  <= du;
      dd_q  <= dd;
      ml_q  <= mag_t'(dl[POS_W-1] ? ndl : dl);
      mr_q  <= mag_t'(dr[POS_W-1] ? ndr : dr);
      mu_q  <= mag_t'(du[POS_W-1] ? ndu : du);
      md_q  <= mag_t'(dd[POS_W-1] ? ndd : dd);
    end
  end

  // Load the dropped rectangle, then push by the smallest distance
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pos_x  <= pos_t'(in_rect.ox);
      pos_y  <= pos_t'(in_rect.oy);
      drop_w <= in_rect.ew;
      drop_h <= in_rect.eh;
    end else if (cmd.move_en && hit_q) begin
      priority if (ml_q <= mr_q && ml_q <= mu_q && ml_q <= md_q) begin
        pos_x <= pos_x + dl_q;
      end else if (mr_q <= mu_q && mr_q <= md_q) begin
        pos_x <= pos_x + dr_q;
      end else if (mu_q <= md_q) begin
        pos_y <= pos_y + du_q;
      end else begin
        pos_y <= pos_y + dd_q;
      end
    end
  end

  // Output register: hold the word until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {sat_coord(pos_y), sat_coord(pos_x)};
    end
  end

  assign sts.hit      = hit_q;
  assign sts.out_busy = m_tvalid && !m_tready;

endmodule

// File: hdl/rect_overlap_pushout_core.sv
// ----------------------------------------------------------------------------
// rect_overlap_pushout_core
// Pushes a dropped rectangle out of a table of loaded rectangles.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one word per item; s_tuser carries the operation
//   (clear, load, resolve) and s_tdata the rectangle. Clear and load give no
//   result. Each resolve gives one word on the master channel with the
//   pushed position, saturated to 24 bits.
//   A resolve walks the table in load order; for each entry it forms the
//   edge distances from the registered table read, then compares and
//   pushes, for up to 10 passes, stopping after a pass with no overlap.
//   With an empty table it goes straight to handing off the result.
//   s_tready is high only while the block is idle.
//   The result sits in an output register; a new item is accepted while it
//   waits. If the receiver still stalls when the next resolve finishes, that
//   resolve waits in its last step until the register frees.
//   Reset clears the table count and the output valid; table contents are
//   left as they are and never read before they are written again.
// ----------------------------------------------------------------------------
module rect_overlap_pushout_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // coord_x[23:0], coord_y[47:24], size_w[63:48], size_h[79:64]
  input  logic [rop_pkg::IN_W-1:0]  s_tdata,
  // op[1:0]
  input  logic [rop_pkg::OP_W-1:0]  s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // final_x[23:0], final_y[47:24]
  output logic [rop_pkg::OUT_W-1:0] m_tdata
);
  import rop_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  rop_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op       (s_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Table and arithmetic
  rop_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: hdl/rop_checker.sv
// ----------------------------------------------------------------------------
// rop_checker
// Port-level checks for the rectangle overlap push-out core.
// ----------------------------------------------------------------------------
module rop_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic [rop_pkg::IN_W-1:0]  s_tdata,
  input logic [rop_pkg::OP_W-1:0]  s_tuser,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [rop_pkg::OUT_W-1:0] m_tdata
);
  import rop_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed or dropped while stalled");

  // Only a resolve produces a result
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser != OP_RESOLVE) |=> !$rose(m_tvalid))
    else $error("result appeared after a clear or load word");

  // A resolve leaves the block busy in the cycle after it is taken
  a_resolve_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_RESOLVE) |=> !s_tready)
    else $error("input accepted right after a resolve word");

  // A fresh result comes with the block back to idle
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result presented while block still busy");

  // Reset clears the output valid
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid set after reset");

endmodule

bind rect_overlap_pushout_core rop_checker u_rop_checker (.*);

// File: dv/rect_overlap_pushout_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_overlap_pushout_checker
// Watches both stream channels of the push-out core. Keeps its own copy of
// the rectangle table, works out where each dropped rectangle should land,
// and compares every result word with the oldest landing still waiting.
// ----------------------------------------------------------------------------
module rect_overlap_pushout_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  // coord_x[23:0], coord_y[47:24], size_w[63:48], size_h[79:64]
  input  logic [rop_pkg::IN_W-1:0]  s_tdata,
  // op[1:0]
  input  logic [rop_pkg::OP_W-1:0]  s_tuser,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  // final_x[23:0], final_y[47:24]
  input  logic [rop_pkg::OUT_W-1:0] m_tdata,
  output int                        failures,
  output int                        pending
);
  import rop_pkg::*;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } spot_t;

  localparam longint XY_HI = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint XY_LO = -(longint'(1) <<< (COORD_W - 1));

  // Local copy of the rectangle table
  coord_t      scene_x [MAX_RECTS];
  coord_t      scene_y [MAX_RECTS];
  dim_t        scene_w [MAX_RECTS];
  dim_t        scene_h [MAX_RECTS];
  int unsigned scene_count;

  // Landings still owed by the block, oldest first
  spot_t landing_q[$];

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic coord_t clamp_out(input longint v);
    if (v > XY_HI) v = XY_HI;
    if (v < XY_LO) v = XY_LO;
    return coord_t'(v);
  endfunction

  // Walk the table in load order, pushing the drop out of each overlap
  function automatic spot_t settle_drop(input coord_t dx, input coord_t dy,
                                        input dim_t dw, input dim_t dh);
    longint px, py, w, h, ox, oy, ew, eh;
    longint dl, dr, du, dd, best;
    bit     moved;
    int     p;
    int     k;
    spot_t  res;
    px = dx;
    py = dy;
    w  = dw;
    h  = dh;
    for (p = 0; p < PASSES; p++) begin
      moved = 1'b0;
      for (k = 0; k < scene_count; k++) begin
        ox = scene_x[k];
        oy = scene_y[k];
        ew = scene_w[k];
        eh = scene_h[k];
        // Strict overlap only: touching edges never hit
        if (px < ox + ew && px + w > ox && py < oy + eh && py + h > oy) begin
          moved = 1'b1;
          dl = ox - (px + w);
          dr = (ox + ew) - px;
          du = oy - (py + h);
          dd = (oy + eh) - py;
          best = magnitude(dl);
          if (magnitude(dr) < best) best = magnitude(dr);
          if (magnitude(du) < best) best = magnitude(du);
          if (magnitude(dd) < best) best = magnitude(dd);
          // Ties go left, right, up, down in that order
          if (best == magnitude(dl)) begin
            px = px + dl;
          end else if (best == magnitude(dr)) begin
            px = px + dr;
          end else if (best == magnitude(du)) begin
            py = py + du;
          end else begin
            py = py + dd;
          end
        end
      end
      if (!moved) break;
    end
    res.x = clamp_out(px);
    res.y = clamp_out(py);
    return res;
  endfunction

  // Track the table, queue landings and check result words
  always @(posedge clk) begin
    spot_t  want;
    coord_t got_x;
    coord_t got_y;
    int     bad;
    bad = 0;
    if (rst) begin
      landing_q.delete();
      scene_count = 0;
      failures <= 0;
      pending  <= 0;
    end else begin
      // Check a result word against the oldest landing
      if (m_tvalid && m_tready) begin
        got_x = coord_t'(m_tdata[COORD_W-1:0]);
        got_y = coord_t'(m_tdata[2*COORD_W-1:COORD_W]);
        if (landing_q.size() == 0) begin
          $error("unexpected result word: final_x %0d final_y %0d", got_x, got_y);
          bad++;
        end else begin
          want = landing_q.pop_front();
          if (got_x !== want.x) begin
            $error("final_x mismatch: expected %0d, actual %0d", want.x, got_x);
            bad++;
          end
          if (got_y !== want.y) begin
            $error("final_y mismatch: expected %0d, actual %0d", want.y, got_y);
            bad++;
          end
        end
      end
      // Apply an accepted input word to the table or queue a landing
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          OP_CLEAR: begin
            scene_count = 0;
          end
          OP_LOAD: begin
            // Drop loads once the table is full
            if (scene_count < MAX_RECTS) begin
              scene_x[scene_count] = coord_t'(s_tdata[COORD_W-1:0]);
              scene_y[scene_count] = coord_t'(s_tdata[2*COORD_W-1:COORD_W]);
              scene_w[scene_count] = s_tdata[2*COORD_W+SIZE_W-1:2*COORD_W];
              scene_h[scene_count] = s_tdata[2*COORD_W+2*SIZE_W-1:2*COORD_W+SIZE_W];
              scene_count++;
            end
          end
          OP_RESOLVE: begin
            landing_q.push_back(settle_drop(
              coord_t'(s_tdata[COORD_W-1:0]),
              coord_t'(s_tdata[2*COORD_W-1:COORD_W]),
              s_tdata[2*COORD_W+SIZE_W-1:2*COORD_W],
              s_tdata[2*COORD_W+2*SIZE_W-1:2*COORD_W+SIZE_W]));
          end
          default: begin
            // Spare op: no effect
          end
        endcase
      end
      failures <= failures + bad;
      pending  <= landing_q.size();
    end
  end

endmodule

// File: dv/tb_rect_overlap_pushout_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rect_overlap_pushout_core
// Drives the push-out core with directed corner cases (empty table, edge
// ties, zero sizes, saturation at all four range limits, spare op) and then
// random scenes: mostly a clear, a cluster of loads, sometimes past capacity, and a
// few drops near the cluster. Both channels idle at random; the checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_rect_overlap_pushout_core;
  import rop_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam coord_t XY_MAX = coord_t'((2 ** (COORD_W - 1)) - 1);
  localparam coord_t XY_MIN = coord_t'(-(2 ** (COORD_W - 1)));
  localparam int RANDOM_ITEMS   = 800;
  localparam int TAIL_CYCLES    = 1400;
  localparam int WATCHDOG_LIMIT = 20000;

  logic              clk;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata  = '0;
  logic [OP_W-1:0]   s_tuser  = OP_CLEAR;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  int                failures;
  int                pending;

  int items_sent  = 0;
  bit burst_mode  = 1'b0;
  int stall_left  = 0;
  bit calm        = 1'b0;
  int mode_left   = 0;
  int idle_cycles = 0;

  rect_overlap_pushout_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  rect_overlap_pushout_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .failures (failures),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic dim_t pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    if (r < 15) return dim_t'($urandom);
    return dim_t'($urandom_range(1, 160));
  endfunction

  // Cluster center: mostly anywhere, sometimes hugging a range limit
  function automatic longint pick_base();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return longint'(XY_MAX) - $urandom_range(0, 400);
    if (r < 20) return longint'(XY_MIN) + $urandom_range(0, 400);
    return longint'($urandom_range(0, 16000000)) - 8000000;
  endfunction

  function automatic coord_t near(input longint base, input int spread);
    longint v;
    v = base + longint'($urandom_range(0, 2 * spread)) - spread;
    if (v > XY_MAX) v = XY_MAX;
    if (v < XY_MIN) v = XY_MIN;
    return coord_t'(v);
  endfunction

  // Send one word; valid stays high afterwards unless a gap follows
  task automatic send_word(input logic [OP_W-1:0] op, input coord_t x, input coord_t y,
                           input dim_t w, input dim_t h);
    int gap;
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {h, w, y, x};
    do @(posedge clk); while (!s_tready);
    if (op != OP_SPARE) items_sent++;
  endtask

  // Hold off the sender until every landing has come back
  task automatic wait_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_noise();
    send_word(OP_W'($urandom_range(0, 3)), coord_t'($urandom), coord_t'($urandom),
              dim_t'($urandom), dim_t'($urandom));
  endtask

  // Receiver: random stalls, with calm stretches in between
  always @(posedge clk) begin
    if (mode_left == 0) begin
      calm      <= ($urandom_range(0, 3) == 0);
      mode_left <= $urandom_range(50, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 2) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    longint base;
    int     spread;
    int     n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table and spare op
    send_word(OP_RESOLVE, XY_MAX, XY_MAX, '1, '1);
    send_word(OP_RESOLVE, XY_MIN, XY_MIN, '0, '0);
    send_word(OP_SPARE, coord_t'($urandom), coord_t'($urandom), dim_t'($urandom),
              dim_t'($urandom));

    // Edge ties against one square
    send_word(OP_CLEAR, 0, 0, 0, 0);
    send_word(OP_LOAD, 0, 0, 100, 100);
    send_word(OP_RESOLVE, 40, 40, 20, 20);
    send_word(OP_RESOLVE, 70, 10, 20, 20);
    send_word(OP_RESOLVE, -50, 40, 200, 20);
    send_word(OP_RESOLVE, 40, 80, 20, 10);

    // Zero-width entry and zero-size drop
    send_word(OP_CLEAR, 0, 0, 0, 0);
    send_word(OP_LOAD, 0, 0, 0, 100);
    send_word(OP_RESOLVE, -10, 10, 50, 20);
    send_word(OP_LOAD, 0, 0, 100, 100);
    send_word(OP_RESOLVE, 10, 10, 0, 0);

    // Pushes past each range limit saturate
    send_word(OP_CLEAR, 0, 0, 0, 0);
    send_word(OP_LOAD, XY_MIN, -30000, '1, '1);
    send_word(OP_RESOLVE, XY_MIN, 0, 10, 10);
    send_word(OP_CLEAR, 0, 0, 0, 0);
    send_word(OP_LOAD, coord_t'(XY_MAX - 5), -40000, 100, '1);
    send_word(OP_RESOLVE, XY_MAX, 0, '1, 20);
    send_word(OP_CLEAR, 0, 0, 0, 0);
    send_word(OP_LOAD, -30000, coord_t'(XY_MAX - 5), '1, 100);
    send_word(OP_RESOLVE, 0, XY_MAX, 20, '1);
    send_word(OP_CLEAR, 0, 0, 0, 0);
    send_word(OP_LOAD, -30000, XY_MIN, '1, '1);
    send_word(OP_RESOLVE, 0, XY_MIN, 10, 10);
    wait_results();

    // Random scenes: clear, clustered loads, drops near the cluster
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 11) == 0) wait_results();
      burst_mode = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(1, 3)) send_noise();
      end else begin
        base   = pick_base();
        spread = ($urandom_range(0, 3) == 0) ? 2000 : 250;
        if ($urandom_range(0, 5) != 0) begin
          send_word(OP_CLEAR, coord_t'($urandom), coord_t'($urandom), dim_t'($urandom),
                    dim_t'($urandom));
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
        repeat (n) begin
          send_word(OP_LOAD, near(base, spread), near(base, spread), pick_size(),
                    pick_size());
        end
        repeat ($urandom_range(1, 4)) begin
          send_word(OP_RESOLVE, near(base, spread / 2), near(base, spread / 2),
                    pick_size(), pick_size());
        end
      end
    end

    // Drain and let any stray word show up
    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
